// File: rtl/core/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  localparam int CoordBitsDefault = 12;
  localparam int CfgBits          = 13;
  localparam int CfgIdxBits       = 2;

  localparam logic [CfgBits-1:0] ScreenWidthReset  = 13'd640;
  localparam logic [CfgBits-1:0] ScreenHeightReset = 13'd480;
  localparam int                 CursorXReset      = 320;
  localparam int                 CursorYReset      = 240;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgScreenHeight = 2'd1;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    PhFlags = 2'd0,
    PhDx    = 2'd1,
    PhDy    = 2'd2
  } phase_e;

  // Packet as seen by the cursor logic
  typedef struct packed {
    logic       complete;
    logic       left_btn;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

endpackage

// File: rtl/core/ps2mt_packet.sv
// ----------------------------------------------------------------------------
// ps2mt_packet
// Byte framer: collects flags and dX, flags the dY byte as packet end.
// ----------------------------------------------------------------------------
module ps2mt_packet (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output ps2mt_pkg::pkt_t   pkt_o
);
  import ps2mt_pkg::*;

  phase_e     phase_q, phase_d;
  logic       left_q;
  logic [7:0] dx_q;

  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        PhDx:    phase_d = PhDy;
        PhDy:    phase_d = PhFlags;
        default: phase_d = PhDx;
      endcase
    end
  end

  always_comb begin
    pkt_o          = '0;
    pkt_o.complete = (phase_q == PhDy);
    pkt_o.left_btn = left_q;
    pkt_o.dx       = dx_q;
    pkt_o.dy       = byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFlags;
      left_q  <= 1'b0;
      dx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      // Capture flags on the first byte, dX on the second
      if (step_i && phase_q != PhDx && phase_q != PhDy) begin
        left_q <= byte_i[0];
      end
      if (step_i && phase_q == PhDx) begin
        dx_q <= byte_i;
      end
    end
  end

endmodule

// File: rtl/core/ps2mt_cursor.sv
// ----------------------------------------------------------------------------
// ps2mt_cursor
// Cursor state: applies one packet's deltas with clamping, tracks the button.
// ----------------------------------------------------------------------------
module ps2mt_cursor #(
  parameter int CoordBits = ps2mt_pkg::CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  ps2mt_pkg::pkt_t              pkt_i,
  input  logic [ps2mt_pkg::CfgBits-1:0] width_i,
  input  logic [ps2mt_pkg::CfgBits-1:0] height_i,
  output logic [CoordBits-1:0]         pos_x_o,
  output logic [CoordBits-1:0]         pos_y_o,
  output logic                         left_held_o,
  output logic                         left_pressed_o,
  output logic                         left_released_o
);
  import ps2mt_pkg::*;

  localparam int CmpW = ((CfgBits > CoordBits) ? CfgBits : CoordBits) + 2;

  logic [CoordBits-1:0] cursor_x_q, cursor_y_q;
  logic                 left_down_q;
  logic signed [CmpW-1:0] nx, ny;

  function automatic logic [CoordBits-1:0] clamp(logic signed [CmpW-1:0] v,
                                                 logic [CfgBits-1:0] size);
    logic signed [CmpW-1:0] lim;
    logic signed [CmpW-1:0] top;
    logic [CoordBits-1:0]   res;
    top = CmpW'({CoordBits{1'b1}});
    lim = (size == '0) ? '0 : CmpW'(size) - CmpW'(1);
    if (lim > top) begin
      lim = top;
    end
    if (v < 0) begin
      res = '0;
    end else if (v > lim) begin
      res = lim[CoordBits-1:0];
    end else begin
      res = v[CoordBits-1:0];
    end
    return res;
  endfunction

  // Screen Y grows downward, so subtract dY
  assign nx = CmpW'($signed({1'b0, cursor_x_q})) + CmpW'($signed(pkt_i.dx));
  assign ny = CmpW'($signed({1'b0, cursor_y_q})) - CmpW'($signed(pkt_i.dy));

  assign pos_x_o         = clamp(nx, width_i);
  assign pos_y_o         = clamp(ny, height_i);
  assign left_held_o     = pkt_i.left_btn;
  assign left_pressed_o  = pkt_i.left_btn & ~left_down_q;
  assign left_released_o = ~pkt_i.left_btn & left_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= CoordBits'(CursorXReset);
      cursor_y_q  <= CoordBits'(CursorYReset);
      left_down_q <= 1'b0;
    end else if (step_i) begin
      cursor_x_q  <= pos_x_o;
      cursor_y_q  <= pos_y_o;
      left_down_q <= pkt_i.left_btn;
    end
  end

endmodule

// File: rtl/core/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Assembles PS/2 mouse bytes into packets and tracks cursor and left button.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel  : one mouse byte per transfer (flags, dX, dY in turn).
//   res channel : one transfer per completed packet carrying the clamped
//                 cursor position and the left button level and edges.
//   cfg channel : register writes (screen width, screen height); always
//                 ready. Write only while no packet is in flight.
// Result path: a dY byte goes from the input register into the result
//   register once that register is free. Flags and dX bytes produce no result.
// Throughput: one byte per cycle while no held result stalls a dY byte,
//   limited by the single input register and the single result register.
// Reset: cursor goes to (320, 240), button released, framer expects a
//   flags byte, screen size returns to 640 x 480.
// Stall: a held result keeps the next dY byte in the input register; flags
//   and dX bytes still pass, so up to three bytes of the next packet are
//   taken before rx ready drops.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
  parameter int CoordBits = ps2mt_pkg::CoordBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rx_valid_i,
  output logic                              rx_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic [CoordBits-1:0]              pos_x_o,
  output logic [CoordBits-1:0]              pos_y_o,
  output logic                              left_held_o,
  output logic                              left_pressed_o,
  output logic                              left_released_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ps2mt_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [ps2mt_pkg::CfgBits-1:0]     cfg_data_i
);
  import ps2mt_pkg::*;

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic [CfgBits-1:0] width_q, height_q;
  logic               out_valid_q;
  logic [CoordBits-1:0] pos_x_q, pos_y_q;
  logic               held_q, pressed_q, released_q;

  pkt_t               pkt;
  logic               advance, step, fire;
  logic [CoordBits-1:0] nxt_x, nxt_y;
  logic               nxt_held, nxt_pressed, nxt_released;

  assign advance    = ~out_valid_q | res_ready_i;
  assign step       = in_valid_q & (~pkt.complete | advance);
  assign fire       = step & pkt.complete;
  assign rx_ready_o = ~in_valid_q | step;
  assign cfg_ready_o = 1'b1;

  ps2mt_packet u_packet (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .pkt_o  (pkt)
  );

  ps2mt_cursor #(
    .CoordBits (CoordBits)
  ) u_cursor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (fire),
    .pkt_i           (pkt),
    .width_i         (width_q),
    .height_i        (height_q),
    .pos_x_o         (nxt_x),
    .pos_y_o         (nxt_y),
    .left_held_o     (nxt_held),
    .left_pressed_o  (nxt_pressed),
    .left_released_o (nxt_released)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthReset;
      height_q <= ScreenHeightReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgScreenWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgScreenHeight) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pos_x_q    <= nxt_x;
      pos_y_q    <= nxt_y;
      held_q     <= nxt_held;
      pressed_q  <= nxt_pressed;
      released_q <= nxt_released;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign left_held_o     = held_q;
  assign left_pressed_o  = pressed_q;
  assign left_released_o = released_q;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 mouse packet tracker. A small scoreboard
// class follows the byte framing, cursor arithmetic with clamping and left
// button edges, and checks every result transfer against its own prediction.
// Directed packets and screen sizes come first, then random phases with
// random screen sizes, drifting deltas and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ps2mt_pkg::*;

  localparam int CoordW     = CoordBitsDefault;
  localparam int ByteTarget = 850;
  localparam int CycleLimit = 400000;

  // Indexes past the two screen registers; writes there must be dropped.
  localparam logic [CfgIdxBits-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgSpare3 = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              held;
    logic              pressed;
    logic              released;
  } cursor_res_t;

  class cursor_scoreboard;
    logic [CfgBits-1:0] width_q;
    logic [CfgBits-1:0] height_q;
    phase_e             phase_q;
    logic [7:0]         flags_q;
    logic [7:0]         dx_q;
    logic [CoordW-1:0]  cx;
    logic [CoordW-1:0]  cy;
    logic               btn_q;
    cursor_res_t        cursor_q[$];
    int                 mismatches;
    int                 results_seen;
    int                 bytes_in;
    int                 cfg_writes;

    function new();
      width_q      = ScreenWidthReset;
      height_q     = ScreenHeightReset;
      phase_q      = PhFlags;
      flags_q      = 8'h00;
      dx_q         = 8'h00;
      cx           = CoordW'(CursorXReset);
      cy           = CoordW'(CursorYReset);
      btn_q        = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      bytes_in     = 0;
      cfg_writes   = 0;
    endfunction

    function int sx8(logic [7:0] v);
      return v[7] ? int'(v) - 256 : int'(v);
    endfunction

    function int clip(int v, logic [CfgBits-1:0] size);
      int top;
      int limit;
      top   = (1 << CoordW) - 1;
      limit = (size == 0) ? 0 : int'(size) - 1;
      if (limit > top) limit = top;
      if (v < 0) return 0;
      if (v > limit) return limit;
      return v;
    endfunction

    function int pending();
      return cursor_q.size();
    endfunction

    function void note_config(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
      cfg_writes++;
      case (idx)
        CfgScreenWidth:  width_q  = val;
        CfgScreenHeight: height_q = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      cursor_res_t r;
      int          nx;
      int          ny;
      logic        btn;
      bytes_in++;
      case (phase_q)
        PhDx: begin
          dx_q    = b;
          phase_q = PhDy;
        end
        PhDy: begin
          phase_q    = PhFlags;
          // screen Y grows downward, so dY is subtracted
          nx         = int'(cx) + sx8(dx_q);
          ny         = int'(cy) - sx8(b);
          cx         = CoordW'(clip(nx, width_q));
          cy         = CoordW'(clip(ny, height_q));
          btn        = flags_q[0];
          r.x        = cx;
          r.y        = cy;
          r.held     = btn;
          r.pressed  = btn && !btn_q;
          r.released = !btn && btn_q;
          btn_q      = btn;
          cursor_q.push_back(r);
        end
        default: begin
          flags_q = b;
          phase_q = PhDx;
        end
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(cursor_res_t got);
      cursor_res_t want;
      results_seen++;
      if (cursor_q.size() == 0) begin
        report($sformatf("ERROR: result with nothing pending: x=%0d y=%0d h=%0b p=%0b r=%0b",
                         got.x, got.y, got.held, got.pressed, got.released));
        return;
      end
      want = cursor_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.held !== want.held ||
          got.pressed !== want.pressed || got.released !== want.released) begin
        report($sformatf(
          "ERROR: packet %0d exp x=%0d y=%0d h=%0b p=%0b r=%0b got x=%0d y=%0d h=%0b p=%0b r=%0b",
          results_seen, want.x, want.y, want.held, want.pressed, want.released,
          got.x, got.y, got.held, got.pressed, got.released));
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  rx_valid_i;
  logic                  rx_ready_o;
  logic [7:0]            rx_byte_i;
  logic                  res_valid_o;
  logic                  res_ready_i;
  logic [CoordW-1:0]     pos_x_o;
  logic [CoordW-1:0]     pos_y_o;
  logic                  left_held_o;
  logic                  left_pressed_o;
  logic                  left_released_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [CfgBits-1:0]    cfg_data_i;

  cursor_scoreboard sb;
  bit               calm;
  bit               squeeze_go;
  int               cycles;

  ps2_mouse_packet_tracker #(
    .CoordBits(CoordW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .left_held_o    (left_held_o),
    .left_pressed_o (left_pressed_o),
    .left_released_o(left_released_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, none at all in a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CfgBits-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return CfgBits'(1);
      2: return '1;
      3: return CfgBits'(4096);
      4: return CfgBits'(4097);
      5: return CfgBits'($urandom_range(0, 8191));
      default: return CfgBits'($urandom_range(1, 4096));
    endcase
  endfunction

  // Delta that mostly pushes the cursor one way, or anything when drift is zero.
  function automatic logic [7:0] pick_delta(int drift);
    if (drift == 0 || $urandom_range(0, 9) < 4) return 8'($urandom);
    if (drift > 0) return 8'($urandom_range(64, 127));
    return 8'(256 - $urandom_range(64, 128));
  endfunction

  // Valid stays high across back-to-back bytes; lowered only for a gap.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sb.note_byte(b);
  endtask

  task automatic send_packet(logic [7:0] flags, logic [7:0] dx, logic [7:0] dy);
    send_byte(flags);
    send_byte(dx);
    send_byte(dy);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, val);
  endtask

  task automatic set_screen(logic [CfgBits-1:0] w, logic [CfgBits-1:0] h, bit spare);
    if ($urandom_range(0, 1)) begin
      write_reg(CfgScreenWidth, w);
      write_reg(CfgScreenHeight, h);
    end else begin
      write_reg(CfgScreenHeight, h);
      write_reg(CfgScreenWidth, w);
    end
    if (spare) begin
      write_reg(CfgSpare2, CfgBits'($urandom));
      write_reg(CfgSpare3, CfgBits'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait out every pending result, then let the pipeline settle.
  task automatic drain();
    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result sink with random back-pressure and one long hold-off.
  initial begin : res_sink
    int stall;
    bit squeezed;
    stall       = 0;
    squeezed    = 0;
    res_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!squeezed && squeeze_go) begin
        squeezed = 1;
        stall    = 250;
      end
      if (stall > 0) begin
        stall--;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      sb.check_result('{x: pos_x_o, y: pos_y_o, held: left_held_o,
                        pressed: left_pressed_o, released: left_released_o});
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("ERROR: timeout after %0d cycles, %0d results pending", cycles, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int npk;
    int dx_drift;
    int dy_drift;
    int phases;
    rst_ni      = 1'b0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgScreenWidth;
    cfg_data_i  = '0;
    calm        = 1'b0;
    squeeze_go  = 1'b0;
    phases      = 0;
    sb          = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset screen: full-scale deltas, dY of -128, press / hold / release
    send_packet(8'h01, 8'h7F, 8'h80);
    send_packet(8'hFF, 8'h80, 8'h7F);
    send_packet(8'hFE, 8'h00, 8'h00);
    drain();
    // shrink below the cursor; it clamps only when the next packet lands
    set_screen(CfgBits'(100), '1, 1'b1);
    send_packet(8'h00, 8'h00, 8'h00);
    send_packet(8'h01, 8'h7F, 8'h80);
    drain();
    set_screen('0, '0, 1'b0);
    send_packet(8'h01, 8'h05, 8'hFB);
    drain();
    set_screen(CfgBits'(1), CfgBits'(1), 1'b0);
    send_packet(8'h00, 8'h7F, 8'h81);
    drain();
    set_screen(CfgBits'(4096), CfgBits'(4096), 1'b0);
    send_packet(8'h02, 8'h80, 8'h80);

    while (sb.bytes_in < ByteTarget) begin
      drain();
      phases++;
      calm = ($urandom_range(0, 4) == 0);
      set_screen(pick_size(), pick_size(), $urandom_range(0, 3) == 0);
      // hold off the sink while a whole phase of packets is still to come
      if (phases == 1) squeeze_go = 1'b1;
      npk      = $urandom_range(10, 40);
      dx_drift = $urandom_range(0, 2) - 1;
      dy_drift = $urandom_range(0, 2) - 1;
      repeat (npk) begin
        send_packet(8'($urandom), pick_delta(dx_drift), pick_delta(dy_drift));
      end
    end
    calm = 1'b0;
    drain();

    $display("Run covered %0d bytes in %0d random phases, %0d cursor packets checked,",
             sb.bytes_in, phases, sb.results_seen);
    $display("%0d register writes, %0d mismatches, %0d cycles", sb.cfg_writes,
             sb.mismatches, cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ps2mt_pkg.sv
rtl/core/ps2mt_packet.sv
rtl/core/ps2mt_cursor.sv
rtl/core/ps2_mouse_packet_tracker.sv
tb/sv/tb_top.sv
